>>> sv/text_term_tokenizer_core_macros.svh
// Assertion macros used by the checker file.
`ifndef TEXT_TERM_TOKENIZER_CORE_MACROS_SVH
`define TEXT_TERM_TOKENIZER_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define TTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Implication whose consequent is checked in the following cycle.
`define TTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

>>> sv/ttt_pkg.sv
`default_nettype none

package ttt_pkg;

  localparam int WORD_DEPTH    = 32;
  localparam int POSITION_BITS = 24;

  localparam int ADDR_W     = $clog2(WORD_DEPTH);
  localparam int CNT_W      = $clog2(WORD_DEPTH + 1);
  localparam int CHAR_W     = 8;
  localparam int TERM_POS_W = 24;
  localparam int DOC_W      = 16;

  typedef struct packed {
    logic [CHAR_W-1:0] data_byte;
    logic              end_of_document;
  } ttt_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]     term_char;
    logic                  term_last;
    logic                  run_last;
    logic [TERM_POS_W-1:0] term_position;
    logic [DOC_W-1:0]      doc_number;
    logic                  truncated;
  } ttt_out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic start;   // begin emitting the stored word
    logic step;    // current char taken, move to the next
    logic finish;  // final char taken, close the word
  } ttt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic flush_req;   // input word ends the current word
    logic word_empty;  // nothing stored
    logic char_last;   // char on the output is the word's last
  } ttt_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ttt_state_e;

endpackage

`default_nettype wire

>>> sv/ttt_ram.sv
`default_nettype none

module ttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/ttt_ctrl.sv
`default_nettype none

module ttt_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire ttt_pkg::ttt_status_t status_i,
  output ttt_pkg::ttt_cmd_t         cmd_o
);
  import ttt_pkg::*;

  ttt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.flush_req && !status_i.word_empty) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i && status_i.char_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.start  = in_valid_i && status_i.flush_req && !status_i.word_empty;
      end
      ST_EMIT: begin
        out_valid_o  = 1'b1;
        cmd_o.step   = out_ready_i && !status_i.char_last;
        cmd_o.finish = out_ready_i && status_i.char_last;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ttt_dp.sv
`default_nettype none

module ttt_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ttt_pkg::ttt_in_t                    in_data_i,
  output ttt_pkg::ttt_out_t                        out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [ttt_pkg::DOC_W-1:0]           cfg_data_i,
  input  wire ttt_pkg::ttt_cmd_t                   cmd_i,
  output ttt_pkg::ttt_status_t                     status_o
);
  import ttt_pkg::*;

  localparam logic [CHAR_W-1:0] CHR_SP   = 8'h20;
  localparam logic [CHAR_W-1:0] CHR_HYP  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHR_NL   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHR_SL   = 8'h2F;
  localparam logic [CHAR_W-1:0] CHR_US   = 8'h5F;
  localparam logic [CHAR_W-1:0] CHR_AT   = 8'h40;
  localparam logic [CHAR_W-1:0] CHR_AMP  = 8'h26;
  localparam logic [CHAR_W-1:0] CHR_D0   = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_D9   = 8'h39;
  localparam logic [CHAR_W-1:0] CHR_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHR_UZ   = 8'h5A;
  localparam logic [CHAR_W-1:0] CHR_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CHR_LZ   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS = CHR_LA - CHR_UA;

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [CNT_W-1:0]         LEN_FULL = CNT_W'(WORD_DEPTH);

  logic [CNT_W-1:0]         len_q, len_d;
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic                     all_dig_q, all_dig_d;
  logic                     ovf_q, ovf_d;
  logic                     eod_q, eod_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [DOC_W-1:0]         doc_q;

  logic [CHAR_W-1:0]        raw, up;
  logic                     is_sep, is_digit, is_kept, flush_req, absorb, word_full;
  logic [POSITION_BITS-1:0] pos_inc;
  logic                     ram_we, ram_re;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [CHAR_W-1:0]        ram_rdata;
  logic                     char_last;

  // byte classification
  always_comb begin
    raw       = in_data_i.data_byte;
    up        = (raw inside {[CHR_LA:CHR_LZ]}) ? raw - CASE_OFS : raw;
    is_sep    = raw inside {CHR_SP, CHR_HYP, CHR_NL, CHR_SL, CHR_US};
    is_digit  = up inside {[CHR_D0:CHR_D9]};
    is_kept   = is_digit || (up inside {[CHR_UA:CHR_UZ]}) || up == CHR_AT || up == CHR_AMP;
    flush_req = in_data_i.end_of_document || is_sep;
    absorb    = cmd_i.accept && !flush_req && is_kept;
    word_full = (len_q == LEN_FULL);
  end

  assign pos_inc   = (pos_q == POS_MAX) ? pos_q : pos_q + POS_ONE;
  assign char_last = ((CNT_W'(idx_q) + CNT_W'(1)) == len_q);

  assign ram_we    = absorb && !word_full;
  assign ram_re    = cmd_i.start || cmd_i.step;
  assign ram_raddr = cmd_i.start ? '0 : idx_q + ADDR_W'(1);

  ttt_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (WORD_DEPTH)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (up),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    len_d     = len_q;
    idx_d     = idx_q;
    all_dig_d = all_dig_q;
    ovf_d     = ovf_q;
    eod_d     = eod_q;
    pos_d     = pos_q;

    if (absorb) begin
      all_dig_d = all_dig_q && is_digit;
      if (word_full) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + CNT_W'(1);
      end
    end

    // separator with nothing stored: only the document end matters
    if (cmd_i.accept && flush_req && !cmd_i.start) begin
      len_d     = '0;
      all_dig_d = 1'b1;
      ovf_d     = 1'b0;
      if (in_data_i.end_of_document) begin
        pos_d = POS_ONE;
      end
    end

    if (cmd_i.start) begin
      idx_d = '0;
      eod_d = in_data_i.end_of_document;
    end

    if (cmd_i.step) begin
      idx_d = idx_q + ADDR_W'(1);
      if (all_dig_q) begin
        pos_d = pos_inc;
      end
    end

    if (cmd_i.finish) begin
      pos_d     = eod_q ? POS_ONE : pos_inc;
      len_d     = '0;
      all_dig_d = 1'b1;
      ovf_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      idx_q     <= '0;
      all_dig_q <= 1'b1;
      ovf_q     <= 1'b0;
      eod_q     <= 1'b0;
      pos_q     <= POS_ONE;
      doc_q     <= DOC_W'(1);
    end else begin
      len_q     <= len_d;
      idx_q     <= idx_d;
      all_dig_q <= all_dig_d;
      ovf_q     <= ovf_d;
      eod_q     <= eod_d;
      pos_q     <= pos_d;
      if (cfg_we_i) begin
        doc_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    out_data_o.term_char     = ram_rdata;
    out_data_o.term_last     = all_dig_q || char_last;
    out_data_o.run_last      = char_last;
    out_data_o.term_position = TERM_POS_W'(pos_q);
    out_data_o.doc_number    = doc_q;
    out_data_o.truncated     = ovf_q;
  end

  assign status_o.flush_req  = flush_req;
  assign status_o.word_empty = (len_q == '0);
  assign status_o.char_last  = char_last;

endmodule

`default_nettype wire

>>> sv/text_term_tokenizer_core.sv
// Term tokenizer. Takes document text one byte per input word and emits the
// terms it finds one character per output word. Space, hyphen, newline, slash,
// underscore and the end-of-document flag close a word; letters are folded to
// upper case; anything other than digits, letters, '@' and '&' is dropped.
// An all-digit word comes out as one-digit terms, each with its own position.
// Every output word carries the term position (from 1 per document,
// saturating), the document number last written on cfg_data_i, and a
// truncated flag when the word had more than WORD_DEPTH kept characters (only
// the first WORD_DEPTH are emitted). run_last marks the final output word of
// a flush. A byte that does not close a word is taken directly while idle.
// A closing byte of a word with stored characters is taken as well, the
// first character appears in the next cycle (registered read of the word
// RAM), then one character per cycle while out_ready_i is high; no further
// byte is taken until the last character is taken. The word RAM's single
// read port sets the one-character-per-cycle output rate. Write cfg_data_i only while idle.
`default_nettype none

module text_term_tokenizer_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire ttt_pkg::ttt_in_t          in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output ttt_pkg::ttt_out_t              out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [ttt_pkg::DOC_W-1:0] cfg_data_i
);
  import ttt_pkg::*;

  ttt_cmd_t    cmd;
  ttt_status_t status;

  // sequencing: idle/accept vs. emitting stored characters
  ttt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // classification, word RAM, position and document registers
  ttt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

`default_nettype wire

>>> sv/ttt_checker.sv
`default_nettype none
`include "text_term_tokenizer_core_macros.svh"

module ttt_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire ttt_pkg::ttt_out_t out_data_o
);
  import ttt_pkg::*;

  // one word in flight: never taking input while emitting
  `TTT_ASSERT_IMP(a_no_overlap, out_valid_o, !in_ready_o)

  // stalled output holds
  `TTT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o))

  // a flush continues without gaps until run_last
  `TTT_ASSERT_NEXT(a_run_cont, out_valid_o && out_ready_i && !out_data_o.run_last,
                   out_valid_o)

  // end of a run returns to taking input
  `TTT_ASSERT_NEXT(a_run_end, out_valid_o && out_ready_i && out_data_o.run_last,
                   !out_valid_o && in_ready_o)

  // a run always closes a term
  `TTT_ASSERT_IMP(a_run_term, out_valid_o && out_data_o.run_last, out_data_o.term_last)

endmodule

bind text_term_tokenizer_core ttt_checker u_ttt_checker (.*);

`default_nettype wire
